FILE: sv/cwa_pkg.sv
// Shared types and constants of the centered window average block.
// Depends on nothing; the top, front and back refer to it by scoped names, the testbench imports it.
`default_nettype none

package cwa_pkg;

    // Fixed widths of the stream fields.
    localparam int SAMPLE_W    = 16;
    localparam int COL_W       = 16;

    // Configuration port.
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int HALF_CFG_W  = 5;

    // Entries in the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLUMN_COUNT = 1'b0,
        REG_HALF_WINDOW  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [COL_W-1:0]      column_count;
        logic [HALF_CFG_W-1:0] half_window;
    } cfg_t;

    // Result attributes that travel with each job.
    typedef struct packed {
        logic [COL_W-1:0] column;
        logic             last;
        logic             window_error;
    } tag_t;

endpackage

`default_nettype wire

FILE: sv/centered_window_average.sv
// Top level of the centered window average block: configuration registers,
// front, job queue and divider back. Depends on cwa_pkg, cwa_queue, cwa_front, cwa_back.
`default_nettype none

// Channel   Direction  Width  Contents
// s_axis    in         16     tdata: sample (bits 15:0)
// m_axis    out        32     tdata: smoothed (15:0), column_index (31:16);
//                             tlast: last; tuser: window_error
// cfg       in         1+16   index 0 column_count, index 1 half_window
//
// The front accepts a sample in F_IDLE and then steps through its candidate
// columns in F_GEN, each step waiting for queue room; the final column of a run
// sweeps min(H, N-1) + 1 candidates.
// A smoothed result passes through the bit-serial divider, which takes a new job
// only after handing its last result to the output register, so the divider sets
// the sustained rate; jobs of size one, such as raw results, skip the division.
// Reset needs no clearing pass: prefix index zero of a run is held in a
// register, and every other ring slot is written before it is read.
// A four-entry queue lets the front keep taking samples while the divider or
// the output side stalls, and the output register holds a transaction until taken.

module centered_window_average #(
    parameter int MAX_HALF   = 31,
    parameter int RING_DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: sample[15:0].
    input  wire logic [cwa_pkg::SAMPLE_W-1:0]     s_axis_tdata,

    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // Fields from bit 0: smoothed[15:0], column_index[31:16].
    output logic [cwa_pkg::SAMPLE_W+cwa_pkg::COL_W-1:0] m_axis_tdata,
    output logic                                  m_axis_tlast,
    // Fields from bit 0: window_error.
    output logic                                  m_axis_tuser,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cwa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cwa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int SZ_W  = $clog2(2 * MAX_HALF + 2);
    localparam int SUM_W = cwa_pkg::SAMPLE_W + SZ_W;
    localparam int JOB_W = SUM_W + SZ_W + $bits(cwa_pkg::tag_t);

    cwa_pkg::cfg_t cfg_reg;

    logic                                job_push, job_pop, job_empty, job_room;
    logic [SUM_W-1:0]                    push_sum, pop_sum;
    logic [SZ_W-1:0]                     push_size, pop_size;
    cwa_pkg::tag_t                       push_tag, pop_tag, out_tag;
    logic [cwa_pkg::SAMPLE_W-1:0]        out_smoothed;

    // Configuration writes are always taken; only listed indexes change state.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.column_count <= cwa_pkg::COL_W'(1);
            cfg_reg.half_window  <= '0;
        end else if (cfg_valid) begin
            case (cwa_pkg::cfg_index_t'(cfg_index))
                cwa_pkg::REG_COLUMN_COUNT: begin
                    cfg_reg.column_count <= cfg_data;
                end
                cwa_pkg::REG_HALF_WINDOW: begin
                    cfg_reg.half_window <= cfg_data[cwa_pkg::HALF_CFG_W-1:0];
                end
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    cwa_front #(
        .MAX_HALF   (MAX_HALF),
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata),
        .queue_room (job_room),
        .job_push   (job_push),
        .job_sum    (push_sum),
        .job_size   (push_size),
        .job_tag    (push_tag)
    );

    cwa_queue #(
        .WIDTH (JOB_W),
        .DEPTH (cwa_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data ({push_sum, push_size, push_tag}),
        .pop       (job_pop),
        .pop_data  ({pop_sum, pop_size, pop_tag}),
        .empty     (job_empty),
        .has_room  (job_room)
    );

    cwa_back #(
        .MAX_HALF (MAX_HALF)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!job_empty),
        .job_pop      (job_pop),
        .job_sum      (pop_sum),
        .job_size     (pop_size),
        .job_tag      (pop_tag),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_smoothed (out_smoothed),
        .out_tag      (out_tag)
    );

    assign m_axis_tdata = {out_tag.column, out_smoothed};
    assign m_axis_tlast = out_tag.last;
    assign m_axis_tuser = out_tag.window_error;

endmodule

`default_nettype wire

FILE: sv/cwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module cwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/cwa_queue.sv
// Small flop-based queue that decouples the front from the back.
// Depends on nothing.
`default_nettype none

module cwa_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] pop_data,
    output logic                  empty,
    output logic                  has_room
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    // Room for two more entries: one being produced and one in flight.
    assign has_room = ((32'(count_reg) + 32'd2) <= 32'(DEPTH));

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The front only pushes while it has checked for room.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (32'(count_reg) < 32'(DEPTH)) || pop)
        else $error("queue pushed while full");

endmodule

`default_nettype wire

FILE: sv/cwa_front.sv
// Front of the centered window average: takes samples, keeps the prefix sums,
// works out which columns complete and turns each into a division job.
// Depends on cwa_pkg and cwa_ram.
`default_nettype none

module cwa_front #(
    parameter int MAX_HALF   = 31,
    parameter int RING_DEPTH = 64,
    localparam int SZ_W      = $clog2(2 * MAX_HALF + 2),
    localparam int SUM_W     = cwa_pkg::SAMPLE_W + SZ_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cwa_pkg::cfg_t                 cfg,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [cwa_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire logic                          queue_room,
    output logic                               job_push,
    output logic      [SUM_W-1:0]              job_sum,
    output logic      [SZ_W-1:0]               job_size,
    output cwa_pkg::tag_t                      job_tag
);

    localparam int HW_W = $clog2(MAX_HALF + 1);
    localparam int RA_W = $clog2(RING_DEPTH);
    localparam int CW   = cwa_pkg::COL_W;

    typedef enum logic {
        F_IDLE,
        F_GEN
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0]    prefix_reg, prefix_next;
    logic [RA_W-1:0]     slot_reg, slot_next;
    logic                b_valid_reg, b_valid_next;

    logic [CW-1:0]       k_reg, i_reg, end_reg;
    logic [cwa_pkg::SAMPLE_W-1:0] s_reg;
    logic                raw_reg, err_reg;
    logic [SUM_W-1:0]    base_reg;
    logic                b_direct_reg, b_base_sel_reg;
    logic [SZ_W-1:0]     b_size_reg;
    cwa_pkg::tag_t       b_tag_reg;

    logic [CW-1:0]       n, n_m1, k, hw16, hw2, cnt_acc, i_start, i_end, rem_i, h16;
    logic [31:0]         hw_wide, lo_wide;
    logic [HW_W-1:0]     hw;
    logic [CW:0]         k_inc, i_plus_h;
    logic [CW:0]         size_wide;
    logic                raw_mode, accept, step, match, direct, base_sel;
    logic [SUM_W-1:0]    p_after, lo_value, ram_rdata;
    logic [RA_W-1:0]     slot_inc, rd_addr;
    logic [SZ_W-1:0]     size;

    // Effective configuration.
    assign n        = (cfg.column_count == '0) ? CW'(1) : cfg.column_count;
    assign n_m1     = n - 1'b1;
    assign hw_wide  = (32'(cfg.half_window) > 32'(MAX_HALF)) ? 32'(MAX_HALF)
                                                             : 32'(cfg.half_window);
    assign hw       = hw_wide[HW_W-1:0];
    assign hw16     = CW'(hw);
    assign hw2      = hw16 << 1;
    assign raw_mode = (hw == '0) || (hw16 > (n >> 2));

    // Column of the incoming sample; a counter left at or beyond N restarts first.
    assign k        = (cnt_reg >= n) ? '0 : cnt_reg;
    assign k_inc    = {1'b0, k} + 1'b1;
    assign cnt_acc  = (k_inc >= {1'b0, n}) ? '0 : k_inc[CW-1:0];
    assign p_after  = prefix_reg + SUM_W'(in_sample);
    assign slot_inc = (slot_reg == RA_W'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;

    // Candidate columns: one at most inside the run, a sweep on the final column.
    always_comb begin
        if (raw_mode) begin
            i_start = k;
            i_end   = k;
        end else if (k == n_m1) begin
            i_start = (k >= hw16) ? k - hw16 : '0;
            i_end   = k;
        end else begin
            i_start = (k >= hw2) ? k - hw16 : (k >> 1);
            i_end   = i_start;
        end
    end

    assign accept   = in_ready && in_valid;
    assign in_ready = (state_reg == F_IDLE);
    assign step     = (state_reg == F_GEN) && queue_room;

    // Half width of the candidate column and whether its window ends here.
    always_comb begin
        rem_i = n_m1 - i_reg;
        h16   = (i_reg < hw16) ? i_reg : hw16;
        if (rem_i < h16) begin
            h16 = rem_i;
        end
    end

    assign i_plus_h  = {1'b0, i_reg} + {1'b0, h16};
    assign match     = raw_reg || (i_plus_h == {1'b0, k_reg});
    assign direct    = raw_reg || (h16 == '0);
    assign size_wide = {h16, 1'b1};
    assign size      = direct ? SZ_W'(1) : size_wide[SZ_W-1:0];
    assign base_sel  = (i_reg == h16);

    // The low prefix sits size slots below the slot of the current prefix.
    assign lo_wide = (32'(slot_reg) >= 32'(size))
                   ? 32'(slot_reg) - 32'(size)
                   : 32'(slot_reg) + 32'(RING_DEPTH) - 32'(size);
    assign rd_addr = lo_wide[RA_W-1:0];

    cwa_ram #(
        .WIDTH (SUM_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (slot_inc),
        .wr_data (p_after),
        .rd_en   (step && match && !direct),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        prefix_next  = prefix_reg;
        slot_next    = slot_reg;
        b_valid_next = 1'b0;
        case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    state_next  = F_GEN;
                    cnt_next    = cnt_acc;
                    prefix_next = p_after;
                    slot_next   = slot_inc;
                end
            end
            F_GEN: begin
                if (queue_room) begin
                    b_valid_next = match;
                    if (i_reg == end_reg) begin
                        state_next = F_IDLE;
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= F_IDLE;
            cnt_reg     <= '0;
            prefix_reg  <= '0;
            slot_reg    <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            prefix_reg  <= prefix_next;
            slot_reg    <= slot_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            k_reg   <= k;
            s_reg   <= in_sample;
            raw_reg <= raw_mode;
            err_reg <= raw_mode && (hw != '0);
            i_reg   <= i_start;
            end_reg <= i_end;
            if (k == '0) begin
                base_reg <= prefix_reg;
            end
        end else if (step) begin
            if (i_reg != end_reg) begin
                i_reg <= i_reg + 1'b1;
            end
        end
        if (step) begin
            b_direct_reg           <= direct;
            b_base_sel_reg         <= base_sel;
            b_size_reg             <= size;
            b_tag_reg.column       <= i_reg;
            b_tag_reg.last         <= (i_reg == n_m1);
            b_tag_reg.window_error <= err_reg;
        end
    end

    // Window sum from the prefix difference; prefix index zero lives in base_reg.
    assign lo_value = b_base_sel_reg ? base_reg : ram_rdata;
    assign job_push = b_valid_reg;
    assign job_sum  = b_direct_reg ? SUM_W'(s_reg) : prefix_reg - lo_value;
    assign job_size = b_size_reg;
    assign job_tag  = b_tag_reg;

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_GEN) |-> (i_reg <= end_reg) && (end_reg <= k_reg))
        else $error("candidate sweep left its range");

endmodule

`default_nettype wire

FILE: sv/cwa_back.sv
// Back of the centered window average: divides each window sum by its size,
// one quotient bit per cycle, and holds the result for the output stream.
// Depends on cwa_pkg.
`default_nettype none

module cwa_back #(
    parameter int MAX_HALF  = 31,
    localparam int SZ_W     = $clog2(2 * MAX_HALF + 2),
    localparam int SUM_W    = cwa_pkg::SAMPLE_W + SZ_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    output logic                               job_pop,
    input  wire logic [SUM_W-1:0]              job_sum,
    input  wire logic [SZ_W-1:0]               job_size,
    input  wire cwa_pkg::tag_t                 job_tag,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [cwa_pkg::SAMPLE_W-1:0]  out_smoothed,
    output cwa_pkg::tag_t                      out_tag
);

    localparam int SW    = cwa_pkg::SAMPLE_W;
    localparam int CNT_W = $clog2(SW);

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic [SZ_W-1:0] r_reg;
    logic [SW-1:0]   q_reg;
    logic [SZ_W-1:0] size_reg;
    cwa_pkg::tag_t   tag_reg;
    logic [SW-1:0]   out_smoothed_reg;
    cwa_pkg::tag_t   out_tag_reg;

    logic [SZ_W:0]   r_sh, r_sub;
    logic            ge, out_free, load_out;

    assign out_free = !out_valid_reg || out_ready;
    assign job_pop  = (state_reg == B_IDLE) && job_valid;
    assign load_out = (state_reg == B_DONE) && out_free;

    // One restoring step; the quotient is known to fit in SW bits.
    assign r_sh  = {r_reg, q_reg[SW-1]};
    assign ge    = (r_sh >= {1'b0, size_reg});
    assign r_sub = ge ? r_sh - {1'b0, size_reg} : r_sh;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            B_IDLE: begin
                if (job_valid) begin
                    cnt_next   = '0;
                    state_next = (job_size == SZ_W'(1)) ? B_DONE : B_DIV;
                end
            end
            B_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SW - 1)) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (job_pop) begin
            r_reg    <= job_sum[SUM_W-1:SW];
            q_reg    <= job_sum[SW-1:0];
            size_reg <= job_size;
            tag_reg  <= job_tag;
        end else if (state_reg == B_DIV) begin
            r_reg <= r_sub[SZ_W-1:0];
            q_reg <= {q_reg[SW-2:0], ge};
        end
        if (load_out) begin
            out_smoothed_reg <= q_reg;
            out_tag_reg      <= tag_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_smoothed = out_smoothed_reg;
    assign out_tag      = out_tag_reg;

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DIV) |-> (r_reg < size_reg))
        else $error("partial remainder not below divisor");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result shown without a finished division");

endmodule

`default_nettype wire

FILE: sim/centered_window_average_tb.sv
// Self-checking testbench for the centered window average block: drives column
// scores and register writes, predicts every averaged column and compares it.
// Depends on cwa_pkg and centered_window_average.
`timescale 1ns / 1ps

module centered_window_average_tb;

    import cwa_pkg::*;

    // Widths and limits of the block as built here (default parameters).
    localparam int unsigned MAX_HALF     = 31;
    localparam int unsigned RING_DEPTH   = 64;
    localparam int unsigned PERIOD       = 10;
    localparam int unsigned DIRECTED_N   = 24;
    localparam int unsigned RANDOM_N     = 350;
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned HOLD_CYCLES  = 400;

    // After the last expected column has arrived the front may still be
    // sweeping candidates that produce nothing; this margin covers the
    // final-column sweep with room to spare.
    localparam int unsigned DRAIN_CYCLES = 64;

    // Timeout, reckoned from a run in which every item would cause 32 results,
    // each waiting out a full divider pass and a long receiver stall, every
    // item behind a long sender gap, then taken three times over.
    localparam int unsigned ITEM_BUDGET  = 40 + 40 + 32 * (20 + 40);
    localparam int unsigned CYCLE_LIMIT  = 3 * 700 * ITEM_BUDGET + HOLD_CYCLES;

    // One averaged column as seen on the output stream.
    typedef struct packed {
        logic [COL_W-1:0]    smoothed;
        logic [COL_W-1:0]    column;
        logic                last;
        logic                window_error;
    } column_result_t;

    // Rows of the directed table: a sample, or a write of one register.
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_SET_COLUMNS,
        ROW_SET_HALF
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [15:0]       value;
        logic              typed;   // the single expected column is given by hand
        column_result_t    want;
    } plan_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [SAMPLE_W-1:0]        s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [SAMPLE_W+COL_W-1:0]  m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       m_axis_tuser;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    // Shadow copy of the registers and of the block's running state.
    logic [15:0]                shadow_cols;
    logic [4:0]                 shadow_half;
    int unsigned                next_column;
    logic [63:0]                prefix_ring [RING_DEPTH];
    logic [63:0]                prefix_total;

    // Columns caused by the latest sample, and all columns still owed.
    column_result_t             step_columns [$];
    column_result_t             pending_columns [$];

    int unsigned                fault_count;
    int unsigned                items_sent;
    int unsigned                cycle_count;
    bit                         sender_quiet;
    bit                         hold_pending;

    centered_window_average dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // Works out the columns completed by one sample. The window of column i
    // has half width h = min(i, H, N-1-i) and is complete once sample i+h is
    // in, so a sample finishes at most one column per candidate, and the last
    // sample of a sequence flushes the whole tail. Sums are differences of
    // prefix sums held in a ring indexed by column modulo the ring depth.
    function automatic void predict_columns(input logic [15:0] score);
        int unsigned    n;
        int unsigned    hw;
        int unsigned    k;
        int unsigned    i;
        int unsigned    h;
        logic [63:0]    hi;
        logic [63:0]    lo;
        logic [63:0]    quotient;
        column_result_t res;

        step_columns.delete();
        n  = (shadow_cols == 0) ? 1 : shadow_cols;
        hw = (shadow_half > MAX_HALF) ? MAX_HALF : shadow_half;

        // A counter left at or beyond a lowered length restarts the sequence.
        if (next_column >= n)
            next_column = 0;
        k = next_column;

        if (k == 0)
            prefix_ring[0] = prefix_total;
        prefix_total = prefix_total + score;
        prefix_ring[(k + 1) % RING_DEPTH] = prefix_total;

        if (hw == 0 || hw > n / 4) begin
            // Raw pass-through; flagged when the window cannot fit N/4.
            res.smoothed     = score;
            res.column       = k[15:0];
            res.last         = (k == n - 1);
            res.window_error = (hw != 0);
            step_columns.push_back(res);
        end
        else begin
            i = (k >= hw) ? k - hw : 0;
            while (i <= k) begin
                h = (i < hw) ? i : hw;
                if (n - 1 - i < h)
                    h = n - 1 - i;
                if (i + h == k) begin
                    hi               = prefix_ring[(i + h + 1) % RING_DEPTH];
                    lo               = prefix_ring[(i - h) % RING_DEPTH];
                    quotient         = (hi - lo) / (2 * h + 1);
                    res.smoothed     = quotient[15:0];
                    res.column       = i[15:0];
                    res.last         = (i == n - 1);
                    res.window_error = 1'b0;
                    step_columns.push_back(res);
                end
                i++;
            end
        end

        next_column = (k + 1 >= n) ? 0 : k + 1;
    endfunction

    // Gap or stall length: mostly short, now and then a long one.
    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one sample and waits for its transaction; the expected columns
    // are queued at the edge where the sample is taken.
    task automatic push_sample(input logic [15:0] score, input logic typed,
                               input column_result_t want);
        int unsigned gap;

        gap = (sender_quiet || $urandom_range(0, 99) < 65) ? 0 : draw_gap();
        @(negedge clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= score;
        do @(posedge clk); while (!s_axis_tready);
        predict_columns(score);
        if (typed)
            pending_columns.push_back(want);
        else
            foreach (step_columns[j])
                pending_columns.push_back(step_columns[j]);
        items_sent++;
    endtask

    // Brings the block to rest: no sample offered, every owed column taken,
    // and time for a sweep that yields nothing to finish.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_columns.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_COLUMN_COUNT)
            shadow_cols = value;
        else
            shadow_half = value[4:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, quiet stretches without stalls, and one long
    // hold-off on request that lets the block fill up and stall its input.
    initial begin : receiver
        int unsigned stall_left;
        int unsigned window_left;
        bit          rx_quiet;

        stall_left  = 0;
        window_left = 0;
        rx_quiet    = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (window_left == 0) begin
                window_left = 64;
                rx_quiet    = ($urandom_range(0, 3) == 0);
            end
            window_left--;
            if (hold_pending) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_pending = 0;
            end
            else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_axis_tready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 99) < 25)
                    stall_left = draw_gap();
            end
        end
    end

    // Output checker: every transaction on the master side is matched with
    // the oldest owed column, field by field.
    column_result_t seen_column;
    column_result_t owed_column;

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_column = '{m_axis_tdata[15:0], m_axis_tdata[31:16],
                            m_axis_tlast, m_axis_tuser};
            if (pending_columns.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_MAX)
                    $display("unexpected column: smoothed=%h col=%0d last=%b err=%b",
                             seen_column.smoothed, seen_column.column,
                             seen_column.last, seen_column.window_error);
            end
            else begin
                owed_column = pending_columns.pop_front();
                if (seen_column.smoothed !== owed_column.smoothed
                        || seen_column.column !== owed_column.column
                        || seen_column.last !== owed_column.last
                        || seen_column.window_error !== owed_column.window_error) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("column mismatch: expected smoothed=%h col=%0d last=%b err=%b, got smoothed=%h col=%0d last=%b err=%b",
                                 owed_column.smoothed, owed_column.column,
                                 owed_column.last, owed_column.window_error,
                                 seen_column.smoothed, seen_column.column,
                                 seen_column.last, seen_column.window_error);
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        plan_row_t      plan [$];
        column_result_t none;
        int unsigned    n;
        int unsigned    h;
        int unsigned    count;
        int unsigned    sel;
        logic [15:0]    score;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_COLUMN_COUNT;
        cfg_data      = '0;
        shadow_cols   = 16'd1;
        shadow_half   = 5'd0;
        next_column   = 0;
        prefix_total  = '0;
        foreach (prefix_ring[j])
            prefix_ring[j] = '0;
        fault_count   = 0;
        items_sent    = 0;
        cycle_count   = 0;
        sender_quiet  = 0;
        hold_pending  = 0;
        none          = '0;

        // Directed table. After reset N = 1 and H = 0, so each sample is its
        // own final column. A zero length acts as one. Full-scale samples in
        // a smoothed run, then a half width above N/4 that flags raw samples,
        // then the widest window with the longest sequence (upper data bits
        // of the half-width write must be ignored), and finally a shorter
        // length that forces the counter back to zero and flushes the tail.
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b1, '{16'hFFFF, 16'd0, 1'b1, 1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'h0000, 1'b1, '{16'h0000, 16'd0, 1'b1, 1'b0}});
        plan.push_back('{ROW_SET_COLUMNS, 16'd0, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h1234, 1'b1, '{16'h1234, 16'd0, 1'b1, 1'b0}});
        plan.push_back('{ROW_SET_COLUMNS, 16'd8, 1'b0, none});
        plan.push_back('{ROW_SET_HALF, 16'd2, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b1, '{16'hFFFF, 16'd0, 1'b0, 1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0000, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0001, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h8000, 1'b0, none});
        plan.push_back('{ROW_SET_HALF, 16'd3, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hABCD, 1'b1, '{16'hABCD, 16'd0, 1'b0, 1'b1}});
        plan.push_back('{ROW_SAMPLE, 16'h0001, 1'b1, '{16'h0001, 16'd1, 1'b0, 1'b1}});
        plan.push_back('{ROW_SET_COLUMNS, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SET_HALF, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0000, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h5555, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hAAAA, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h7FFF, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h8001, 1'b0, none});
        plan.push_back('{ROW_SET_COLUMNS, 16'd5, 1'b0, none});
        plan.push_back('{ROW_SET_HALF, 16'd1, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0010, 1'b1, '{16'h0010, 16'd0, 1'b0, 1'b0}});
        plan.push_back('{ROW_SAMPLE, 16'h0020, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0030, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'h0040, 1'b0, none});
        plan.push_back('{ROW_SAMPLE, 16'hFFFF, 1'b0, none});

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[r]) begin
            case (plan[r].kind)
                ROW_SET_COLUMNS:
                begin
                    settle();
                    write_reg(REG_COLUMN_COUNT, plan[r].value);
                end
                ROW_SET_HALF:
                begin
                    settle();
                    write_reg(REG_HALF_WINDOW, plan[r].value);
                end
                default:
                    push_sample(plan[r].value, plan[r].typed, plan[r].want);
            endcase
        end

        // Back-pressure phase: a smoothed run with the sender never pausing
        // while the receiver holds off for a long stretch.
        settle();
        write_reg(REG_COLUMN_COUNT, 16'd48);
        write_reg(REG_HALF_WINDOW, 16'd5);
        sender_quiet = 1;
        hold_pending = 1;
        repeat (96)
            push_sample($urandom, 1'b0, none);

        // Random phases. Most are whole sequences with smoothing on, so the
        // tail flush is reached often; some stop mid-sequence, some pass raw
        // samples or trip the window-size flag, and a few use long lengths.
        while (items_sent < DIRECTED_N + RANDOM_N) begin
            settle();
            sel = $urandom_range(0, 3);
            if (sel != 1) begin
                case ($urandom_range(0, 9))
                    0:       n = $urandom_range(0, 3);
                    8:       n = $urandom_range(100, 200);
                    9:       n = $urandom_range(1000, 65535);
                    default: n = $urandom_range(4, 40);
                endcase
                write_reg(REG_COLUMN_COUNT, n[15:0]);
            end
            n = (shadow_cols == 0) ? 1 : shadow_cols;
            if (sel != 0) begin
                h = $urandom_range(0, 9);
                if (h < 6 && n >= 4)
                    h = $urandom_range(1, (n / 4 > MAX_HALF) ? MAX_HALF : n / 4);
                else if (h >= 8 && n / 4 < MAX_HALF)
                    h = $urandom_range(n / 4 + 1, MAX_HALF);
                else
                    h = 0;
                write_reg(REG_HALF_WINDOW, {$urandom_range(0, 2047), h[4:0]});
            end

            if (n >= 1000)
                count = $urandom_range(20, 60);
            else if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, n);
            else
                count = n * $urandom_range(1, 2);

            sender_quiet = ($urandom_range(0, 3) == 0);
            repeat (count) begin
                if ($urandom_range(0, 15) == 0)
                    score = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                else
                    score = $urandom;
                push_sample(score, 1'b0, none);
            end
        end

        settle();
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
sv/cwa_pkg.sv
sv/cwa_ram.sv
sv/cwa_queue.sv
sv/cwa_front.sv
sv/cwa_back.sv
sv/centered_window_average.sv
sim/centered_window_average_tb.sv
